### hdl/pfba_pkg.sv
// Shared types, operation codes and constants for the page frame bitmap allocator.
package pfba_pkg;

  // Default geometry of the bitmap
  localparam int ROWS_DEF      = 512;
  localparam int WORD_BITS_DEF = 64;

  // Address and frame field geometry
  localparam int ADDR_W        = 27;
  localparam int FRAME_SHIFT   = 12;
  localparam int FRAME_IN_W    = ADDR_W - FRAME_SHIFT;
  localparam int LOW_MB_FRAMES = 256;

  // Bit offsets within one row, wide enough to hold a row width of up to 64
  localparam int OFS_W = 7;

  // Operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  // Per-row range controls handed from the sequencer to the row unit
  typedef struct packed {
    logic             set_en;
    logic [OFS_W-1:0] set_lo;
    logic [OFS_W-1:0] set_hi;
    logic             clr_en;
    logic [OFS_W-1:0] clr_hi;
  } row_ctl_t;

endpackage

### hdl/pfba_row_unit.sv
// Shared row unit: updates one bitmap row for allocate, free, init range and query.
module pfba_row_unit #(
  parameter int WORD_BITS = pfba_pkg::WORD_BITS_DEF
) (
  input  logic [WORD_BITS-1:0]         row_word,
  input  logic [1:0]                   op,
  input  pfba_pkg::row_ctl_t           ctl,
  output logic [WORD_BITS-1:0]         new_word,
  output logic                         hit,
  output logic [$clog2(WORD_BITS)-1:0] col,
  output logic                         qbit
);

  localparam int CW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] lowest;
  logic [WORD_BITS-1:0] set_mask;
  logic [WORD_BITS-1:0] clr_mask;

  // Isolate the lowest free bit and encode its position
  always_comb begin
    lowest = row_word & (~row_word + WORD_BITS'(1));
    hit    = |row_word;
    col    = '0;
    for (int c = 0; c < WORD_BITS; c++) begin
      if (lowest[c]) begin
        col = col | CW'(c);
      end
    end
  end

  // Build the set and clear masks from the row offsets
  always_comb begin
    for (int c = 0; c < WORD_BITS; c++) begin
      set_mask[c] = ctl.set_en && (pfba_pkg::OFS_W'(c) >= ctl.set_lo) &&
                    (pfba_pkg::OFS_W'(c) <= ctl.set_hi);
      clr_mask[c] = ctl.clr_en && (pfba_pkg::OFS_W'(c) <= ctl.clr_hi);
    end
  end

  // Select the updated row per operation
  always_comb begin
    qbit = 1'b0;
    case (op)
      pfba_pkg::OP_ALLOC: new_word = row_word & ~lowest;
      pfba_pkg::OP_FREE:  new_word = row_word | set_mask;
      pfba_pkg::OP_INIT:  new_word = (row_word | set_mask) & ~clr_mask;
      pfba_pkg::OP_QUERY: begin
        new_word = row_word;
        qbit     = |(row_word & set_mask);
      end
      default:            new_word = row_word;
    endcase
  end

endmodule

### hdl/page_frame_bitmap_allocator_unit.sv
// Top level of the page frame bitmap allocator: sequencer, bitmap memory and ports.
//
// The free bitmap lives in a ROWS x WORD_BITS memory with one read and one write
// port, and every operation is a sweep over its rows, one row per cycle, through a
// single shared row unit (read row, update, write back in the next cycle). Allocate
// stops at the first row holding a free frame; free, init range, query and a failed
// allocate visit every row. The block takes one item at a time; in_stall is high
// from the accepted beat until the result is loaded into the output register, and
// a waiting result does not hold off the next input beat. After reset a clearing
// pass writes zero to every row, one row per cycle, during which no input beat is
// taken; configuration writes are taken at any time.
module page_frame_bitmap_allocator_unit #(
  parameter int ROWS      = pfba_pkg::ROWS_DEF,
  parameter int WORD_BITS = pfba_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pfba_pkg::ADDR_W-1:0] cfg_kernel_end_addr,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [pfba_pkg::ADDR_W-1:0] in_page_addr,
  input  logic [pfba_pkg::ADDR_W-1:0] in_range_start,
  input  logic [pfba_pkg::ADDR_W-1:0] in_range_end,
  input  logic [14:0]                 in_frame_number,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pfba_pkg::ADDR_W-1:0] out_alloc_addr,
  output logic                        out_alloc_fail,
  output logic                        out_frame_free
);

  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW     = $clog2(WORD_BITS);
  localparam int TOTAL  = ROWS * WORD_BITS;
  localparam int FW_RAW = $clog2(TOTAL + 1);
  localparam int FW     = (FW_RAW > pfba_pkg::FRAME_IN_W + 1) ? FW_RAW :
                          pfba_pkg::FRAME_IN_W + 1;
  localparam int AW     = pfba_pkg::ADDR_W;
  localparam int FS     = pfba_pkg::FRAME_SHIFT;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  // Bitmap memory
  logic [WORD_BITS-1:0] mem [ROWS];

  // Sequencer state
  logic [1:0]    state_r, state_nxt;
  logic [RW-1:0] rd_row_r, rd_row_nxt;
  logic [FW-1:0] base_r, base_nxt;
  logic          issued_all_r, issued_all_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [FW-1:0] lo_r, lo_nxt;
  logic [FW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] kend_r;

  // Write-back stage
  logic                 b_valid_r, b_valid_nxt;
  logic                 b_last_r, b_last_nxt;
  logic [RW-1:0]        b_row_r, b_row_nxt;
  logic [FW-1:0]        b_base_r, b_base_nxt;
  pfba_pkg::row_ctl_t   b_ctl_r, b_ctl_nxt;
  logic [WORD_BITS-1:0] mem_q_r;

  // Result accumulation and output register
  logic          res_fail_r, res_fail_nxt;
  logic          res_free_r, res_free_nxt;
  logic [AW-1:0] res_addr_r, res_addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_alloc_addr_r, out_alloc_addr_nxt;
  logic          out_alloc_fail_r, out_alloc_fail_nxt;
  logic          out_frame_free_r, out_frame_free_nxt;

  // Combinational helpers
  logic                 in_acc;
  logic                 issue;
  logic                 finish;
  logic                 rd_last;
  logic                 wr_en;
  logic [RW-1:0]        wr_row;
  logic [WORD_BITS-1:0] wr_data;
  pfba_pkg::row_ctl_t   a_ctl;
  logic [FW-1:0]        lo_d, hi_d, lm_d;
  logic [FW-1:0]        kp1, sf;
  logic [FW-1:0]        alloc_frame;
  logic [WORD_BITS-1:0] u_new;
  logic                 u_hit;
  logic [CW-1:0]        u_col;
  logic                 u_qbit;

  assign cfg_ready      = 1'b1;
  assign in_stall       = (state_r != ST_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_alloc_addr = out_alloc_addr_r;
  assign out_alloc_fail = out_alloc_fail_r;
  assign out_frame_free = out_frame_free_r;

  assign rd_last = (rd_row_r == RW'(ROWS - 1));
  assign finish  = (state_r == ST_SCAN) && b_valid_r &&
                   (b_last_r || ((op_r == pfba_pkg::OP_ALLOC) && u_hit));
  assign issue   = (state_r == ST_SCAN) && !issued_all_r && !finish;

  // Row offsets of the set range and of the low 1 MiB for the row being read
  always_comb begin
    lo_d = lo_r - base_r;
    hi_d = hi_r - base_r;
    lm_d = FW'(pfba_pkg::LOW_MB_FRAMES - 1) - base_r;
    a_ctl.set_en = (op_r != pfba_pkg::OP_ALLOC) && (hi_r >= base_r);
    if (lo_r <= base_r) begin
      a_ctl.set_lo = '0;
    end else if (lo_d >= FW'(WORD_BITS)) begin
      a_ctl.set_lo = pfba_pkg::OFS_W'(WORD_BITS);
    end else begin
      a_ctl.set_lo = lo_d[pfba_pkg::OFS_W-1:0];
    end
    if (hi_d >= FW'(WORD_BITS - 1)) begin
      a_ctl.set_hi = pfba_pkg::OFS_W'(WORD_BITS - 1);
    end else begin
      a_ctl.set_hi = hi_d[pfba_pkg::OFS_W-1:0];
    end
    a_ctl.clr_en = (op_r == pfba_pkg::OP_INIT) &&
                   (base_r <= FW'(pfba_pkg::LOW_MB_FRAMES - 1));
    if (lm_d >= FW'(WORD_BITS - 1)) begin
      a_ctl.clr_hi = pfba_pkg::OFS_W'(WORD_BITS - 1);
    end else begin
      a_ctl.clr_hi = lm_d[pfba_pkg::OFS_W-1:0];
    end
  end

  // Shared row update
  pfba_row_unit #(
    .WORD_BITS(WORD_BITS)
  ) u_row (
    .row_word(mem_q_r),
    .op      (op_r),
    .ctl     (b_ctl_r),
    .new_word(u_new),
    .hit     (u_hit),
    .col     (u_col),
    .qbit    (u_qbit)
  );

  assign alloc_frame = b_base_r + FW'(u_col);

  // Init range lower bound: above the kernel end frame
  assign kp1 = FW'(kend_r[AW-1:FS]) + FW'(1);
  assign sf  = FW'(in_range_start[AW-1:FS]);

  // Write port: clearing pass or row write-back
  always_comb begin
    wr_en   = (state_r == ST_CLEAR) || ((state_r == ST_SCAN) && b_valid_r);
    wr_row  = (state_r == ST_CLEAR) ? rd_row_r : b_row_r;
    wr_data = (state_r == ST_CLEAR) ? '0 : u_new;
  end

  // Sequencer and result accumulation
  always_comb begin
    state_nxt          = state_r;
    rd_row_nxt         = rd_row_r;
    base_nxt           = base_r;
    issued_all_nxt     = issued_all_r;
    op_nxt             = op_r;
    lo_nxt             = lo_r;
    hi_nxt             = hi_r;
    b_valid_nxt        = 1'b0;
    b_last_nxt         = b_last_r;
    b_row_nxt          = b_row_r;
    b_base_nxt         = b_base_r;
    b_ctl_nxt          = b_ctl_r;
    res_addr_nxt       = res_addr_r;
    res_fail_nxt       = res_fail_r;
    res_free_nxt       = res_free_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_alloc_addr_nxt = out_alloc_addr_r;
    out_alloc_fail_nxt = out_alloc_fail_r;
    out_frame_free_nxt = out_frame_free_r;

    case (state_r)
      ST_CLEAR: begin
        rd_row_nxt = rd_row_r + RW'(1);
        if (rd_last) begin
          rd_row_nxt = '0;
          state_nxt  = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_func;
          rd_row_nxt     = '0;
          base_nxt       = '0;
          issued_all_nxt = 1'b0;
          res_addr_nxt   = '0;
          res_fail_nxt   = 1'b0;
          res_free_nxt   = 1'b0;
          state_nxt      = ST_SCAN;
          case (in_func)
            pfba_pkg::OP_FREE: begin
              lo_nxt = FW'(in_page_addr[AW-1:FS]);
              hi_nxt = FW'(in_page_addr[AW-1:FS]);
            end
            pfba_pkg::OP_INIT: begin
              lo_nxt = (sf > kp1) ? sf : kp1;
              hi_nxt = FW'(in_range_end[AW-1:FS]);
            end
            pfba_pkg::OP_QUERY: begin
              lo_nxt = FW'(in_frame_number);
              hi_nxt = FW'(in_frame_number);
            end
            default: begin
              lo_nxt = FW'(1);
              hi_nxt = '0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // advance the read side one row
        if (issue) begin
          b_valid_nxt    = 1'b1;
          b_last_nxt     = rd_last;
          b_row_nxt      = rd_row_r;
          b_base_nxt     = base_r;
          b_ctl_nxt      = a_ctl;
          issued_all_nxt = rd_last;
          rd_row_nxt     = rd_row_r + RW'(1);
          base_nxt       = base_r + FW'(WORD_BITS);
        end
        // collect what the written-back row yields
        if (b_valid_r) begin
          if ((op_r == pfba_pkg::OP_ALLOC) && u_hit) begin
            res_addr_nxt = {alloc_frame[pfba_pkg::FRAME_IN_W-1:0], FS'(0)};
          end
          if (op_r == pfba_pkg::OP_QUERY) begin
            res_free_nxt = res_free_r | u_qbit;
          end
        end
        if (finish) begin
          if ((op_r == pfba_pkg::OP_ALLOC) && !u_hit) begin
            res_fail_nxt = 1'b1;
          end
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_alloc_addr_nxt = res_addr_r;
          out_alloc_fail_nxt = res_fail_r;
          out_frame_free_nxt = res_free_r;
          state_nxt          = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      rd_row_r     <= '0;
      issued_all_r <= 1'b0;
      b_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      kend_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      rd_row_r     <= rd_row_nxt;
      issued_all_r <= issued_all_nxt;
      b_valid_r    <= b_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        kend_r <= cfg_kernel_end_addr;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    base_r           <= base_nxt;
    op_r             <= op_nxt;
    lo_r             <= lo_nxt;
    hi_r             <= hi_nxt;
    b_last_r         <= b_last_nxt;
    b_row_r          <= b_row_nxt;
    b_base_r         <= b_base_nxt;
    b_ctl_r          <= b_ctl_nxt;
    res_addr_r       <= res_addr_nxt;
    res_fail_r       <= res_fail_nxt;
    res_free_r       <= res_free_nxt;
    out_alloc_addr_r <= out_alloc_addr_nxt;
    out_alloc_fail_r <= out_alloc_fail_nxt;
    out_frame_free_r <= out_frame_free_nxt;
  end

  // Bitmap read port, registered
  always_ff @(posedge clk) begin
    if (issue) begin
      mem_q_r <= mem[rd_row_r];
    end
  end

  // Bitmap write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  // A new result only comes out of the response state
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RESP)
    else $error("result loaded outside the response state");

  // The write-back stage is only filled by a read issued while scanning
  a_wb_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> $past(state_r) == ST_SCAN)
    else $error("write-back stage valid without a scan read");

  // A failed allocation reports address zero
  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_alloc_fail_r) |-> (out_alloc_addr_r == '0))
    else $error("failed allocation with nonzero address");

  // Query and allocate results never show together
  a_free_no_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_free_r) |-> !out_alloc_fail_r)
    else $error("query result and allocation failure both set");

endmodule

### sim/tb_top.sv
// Testbench for the page frame bitmap allocator: frame map tracker, stimulus and result checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry and operation codes from the shared package
  localparam int ADDR_W        = pfba_pkg::ADDR_W;
  localparam int FRAME_IN_W    = pfba_pkg::FRAME_IN_W;
  localparam int FRAME_SHIFT   = pfba_pkg::FRAME_SHIFT;
  localparam int LOW_MB_FRAMES = pfba_pkg::LOW_MB_FRAMES;
  localparam int ROWS_DEF      = pfba_pkg::ROWS_DEF;
  localparam int WORD_BITS_DEF = pfba_pkg::WORD_BITS_DEF;
  localparam logic [1:0] OP_ALLOC = pfba_pkg::OP_ALLOC;
  localparam logic [1:0] OP_FREE  = pfba_pkg::OP_FREE;
  localparam logic [1:0] OP_INIT  = pfba_pkg::OP_INIT;
  localparam logic [1:0] OP_QUERY = pfba_pkg::OP_QUERY;

  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int TABLE_FRAMES    = ROWS_DEF * WORD_BITS_DEF;
  // Most random traffic stays in a small frame window around the 1 MiB boundary
  localparam int WIN_LO   = 240;
  localparam int WIN_SPAN = 320;

  typedef struct {
    logic [1:0]            func;
    logic [ADDR_W-1:0]     page_addr;
    logic [ADDR_W-1:0]     range_start;
    logic [ADDR_W-1:0]     range_end;
    logic [FRAME_IN_W-1:0] frame_number;
  } frame_req_t;

  typedef struct {
    logic [ADDR_W-1:0] alloc_addr;
    logic              alloc_fail;
    logic              frame_free;
  } frame_result_t;

  // Tracks the free bitmap and the results still owed by the block
  class frame_map_tracker;
    bit [WORD_BITS_DEF-1:0] free_rows [ROWS_DEF];
    bit [ADDR_W-1:0]        kernel_end;
    frame_result_t          pending_results [$];
    int errors;
    int compared;
    int alloc_fails;
    int free_hits;
    int op_count [4];

    function void mark_frame(int fr, bit v);
      if (fr >= TABLE_FRAMES) return;
      free_rows[fr / WORD_BITS_DEF][fr % WORD_BITS_DEF] = v;
    endfunction

    function bit frame_is_free(int fr);
      if (fr >= TABLE_FRAMES) return 1'b0;
      return free_rows[fr / WORD_BITS_DEF][fr % WORD_BITS_DEF];
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Apply one accepted request to the map and queue the result it owes
    function void take_request(frame_req_t req);
      frame_result_t res;
      int first;
      int last;
      int kfr;
      res.alloc_addr = '0;
      res.alloc_fail = 1'b0;
      res.frame_free = 1'b0;
      op_count[req.func]++;
      case (req.func)
        OP_ALLOC: begin
          // lowest row first, then lowest bit
          res.alloc_fail = 1'b1;
          for (int r = 0; r < ROWS_DEF && res.alloc_fail; r++) begin
            if (free_rows[r] != '0) begin
              for (int c = 0; c < WORD_BITS_DEF && res.alloc_fail; c++) begin
                if (free_rows[r][c]) begin
                  free_rows[r][c] = 1'b0;
                  res.alloc_addr = ADDR_W'((r * WORD_BITS_DEF + c) << FRAME_SHIFT);
                  res.alloc_fail = 1'b0;
                end
              end
            end
          end
          if (res.alloc_fail) alloc_fails++;
        end
        OP_FREE: mark_frame(int'(req.page_addr >> FRAME_SHIFT), 1'b1);
        OP_INIT: begin
          // free above the kernel end, then take back the low megabyte
          first = int'(req.range_start >> FRAME_SHIFT);
          last  = int'(req.range_end >> FRAME_SHIFT);
          kfr   = int'(kernel_end >> FRAME_SHIFT);
          for (int f = first; f <= last; f++) begin
            if (f > kfr) mark_frame(f, 1'b1);
          end
          for (int f = 0; f < LOW_MB_FRAMES; f++) mark_frame(f, 1'b0);
        end
        OP_QUERY: begin
          res.frame_free = frame_is_free(int'(req.frame_number));
          if (res.frame_free) free_hits++;
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    // Compare one result beat against the oldest owed result
    function void match_result(logic [ADDR_W-1:0] addr, logic fail, logic ffree);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing outstanding: alloc_addr %h alloc_fail %b frame_free %b",
               addr, fail, ffree);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compared++;
      if (addr !== want.alloc_addr) begin
        $error("alloc_addr: expected %h, actual %h", want.alloc_addr, addr);
        errors++;
      end
      if (fail !== want.alloc_fail) begin
        $error("alloc_fail: expected %b, actual %b", want.alloc_fail, fail);
        errors++;
      end
      if (ffree !== want.frame_free) begin
        $error("frame_free: expected %b, actual %b", want.frame_free, ffree);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [ADDR_W-1:0]     cfg_kernel_end_addr = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_func = OP_ALLOC;
  logic [ADDR_W-1:0]     in_page_addr = '0;
  logic [ADDR_W-1:0]     in_range_start = '0;
  logic [ADDR_W-1:0]     in_range_end = '0;
  logic [FRAME_IN_W-1:0] in_frame_number = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ADDR_W-1:0]     out_alloc_addr;
  logic                  out_alloc_fail;
  logic                  out_frame_free;

  frame_map_tracker map = new();

  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_left = 0;
  int rx_run = 0;
  int cycle_count = 0;

  page_frame_bitmap_allocator_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_kernel_end_addr (cfg_kernel_end_addr),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_page_addr        (in_page_addr),
    .in_range_start      (in_range_start),
    .in_range_end        (in_range_end),
    .in_frame_number     (in_frame_number),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_alloc_addr      (out_alloc_addr),
    .out_alloc_fail      (out_alloc_fail),
    .out_frame_free      (out_frame_free)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  // Check every result beat as it leaves
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      map.match_result(out_alloc_addr, out_alloc_fail, out_frame_free);
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_run > 0) begin
      rx_run--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      rx_run = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
      rx_run = $urandom_range(0, 9);
    end
  end

  function automatic int window_frame();
    return WIN_LO + int'($urandom_range(0, WIN_SPAN));
  endfunction

  // Page address of a frame with random offset bits
  function automatic logic [ADDR_W-1:0] frame_addr(int fr);
    logic [31:0] f32;
    f32 = fr;
    return {f32[FRAME_IN_W-1:0], FRAME_SHIFT'($urandom)};
  endfunction

  function automatic frame_req_t make_request(logic [1:0] op, logic [ADDR_W-1:0] page,
                                              logic [ADDR_W-1:0] first,
                                              logic [ADDR_W-1:0] last,
                                              logic [FRAME_IN_W-1:0] frame);
    frame_req_t req;
    req.func         = op;
    req.page_addr    = page;
    req.range_start  = first;
    req.range_end    = last;
    req.frame_number = frame;
    return req;
  endfunction

  // Mostly window traffic with random unused fields; a little full-range noise
  function automatic frame_req_t rand_request();
    frame_req_t req;
    int pick;
    int fr;
    req.page_addr    = ADDR_W'($urandom);
    req.range_start  = ADDR_W'($urandom);
    req.range_end    = ADDR_W'($urandom);
    req.frame_number = FRAME_IN_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35)      req.func = OP_ALLOC;
    else if (pick < 60) req.func = OP_FREE;
    else if (pick < 70) req.func = OP_INIT;
    else                req.func = OP_QUERY;
    case (req.func)
      OP_FREE: begin
        if ($urandom_range(0, 4) != 0) req.page_addr = frame_addr(window_frame());
      end
      OP_INIT: begin
        if ($urandom_range(0, 49) != 0) begin
          fr = window_frame();
          req.range_start = frame_addr(fr);
          if ($urandom_range(0, 9) == 0)
            req.range_end = frame_addr(fr - int'($urandom_range(1, 4)));
          else
            req.range_end = frame_addr(fr + int'($urandom_range(0, 24)));
        end
      end
      OP_QUERY: begin
        if ($urandom_range(0, 3) != 0) req.frame_number = FRAME_IN_W'(window_frame());
      end
      default: ;
    endcase
    return req;
  endfunction

  // Offer one beat and hold it until taken
  task automatic send_request(frame_req_t req);
    in_valid        <= 1'b1;
    in_func         <= req.func;
    in_page_addr    <= req.page_addr;
    in_range_start  <= req.range_start;
    in_range_end    <= req.range_end;
    in_frame_number <= req.frame_number;
    do @(posedge clk); while (in_stall);
    map.take_request(req);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (map.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_kernel_end(logic [ADDR_W-1:0] v);
    cfg_valid           <= 1'b1;
    cfg_kernel_end_addr <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    map.kernel_end = v;
  endtask

  initial begin
    logic [ADDR_W-1:0] kend_steps [4];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_kernel_end('0);

    // Directed: empty map, frame 0 and top frame, empty range, low MB boundary
    send_request(make_request(OP_QUERY, '0, '0, '0, '0));
    send_request(make_request(OP_ALLOC, '0, '0, '0, '0));
    send_request(make_request(OP_FREE, '0, '0, '0, '0));
    send_request(make_request(OP_QUERY, '0, '0, '0, '0));
    send_request(make_request(OP_ALLOC, '0, '0, '0, '0));
    sender_gap();
    send_request(make_request(OP_FREE, '1, '0, '0, '0));
    send_request(make_request(OP_QUERY, '0, '0, '0, '1));
    send_request(make_request(OP_ALLOC, '0, '0, '0, '0));
    send_request(make_request(OP_ALLOC, '0, '0, '0, '0));
    send_request(make_request(OP_FREE, ADDR_W'(27'h1FFF), '0, '0, '0));
    sender_gap();
    send_request(make_request(OP_INIT, '0, ADDR_W'(27'h5000), ADDR_W'(27'h4000), '0));
    send_request(make_request(OP_QUERY, '0, '0, '0, FRAME_IN_W'(1)));
    send_request(make_request(OP_INIT, '0, ADDR_W'(27'h0FF000), ADDR_W'(27'h104FFF), '0));
    send_request(make_request(OP_QUERY, '0, '0, '0, FRAME_IN_W'(255)));
    send_request(make_request(OP_QUERY, '0, '0, '0, FRAME_IN_W'(256)));
    send_request(make_request(OP_ALLOC, '0, '0, '0, '0));
    sender_gap();
    send_request(make_request(OP_INIT, '0, '1, '1, '0));
    send_request(make_request(OP_QUERY, '0, '0, '0, '1));
    send_request(make_request(OP_ALLOC, '0, '0, '0, '0));

    // Random phases, each under its own kernel end setting
    kend_steps = '{ADDR_W'('1), ADDR_W'(27'h120FFF), ADDR_W'($urandom), ADDR_W'(0)};
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      repeat (4) @(posedge clk);
      write_kernel_end(kend_steps[p]);
      if (p == 3) send_request(make_request(OP_INIT, '0, '0, '1, '0));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        quiet = (p == 3 && i >= ITEMS_PER_PHASE - 100);
        // long receiver hold-off while the sender keeps offering
        if (p == 1 && i == 60) hold_req = 1500;
        // sender pause until the block has answered everything
        if (p == 2 && i == 75) wait_drained();
        if (!(p == 1 && i >= 60 && i < 70)) sender_gap();
        send_request(rand_request());
      end
    end

    wait_drained();
    repeat (ROWS_DEF + 8) @(posedge clk);
    $display("summary: %0d requests (alloc %0d, free %0d, init %0d, query %0d), %0d compared",
             map.op_count[0] + map.op_count[1] + map.op_count[2] + map.op_count[3],
             map.op_count[OP_ALLOC], map.op_count[OP_FREE], map.op_count[OP_INIT],
             map.op_count[OP_QUERY], map.compared);
    $display("summary: %0d failed allocations, %0d queries found a free frame, 5 kernel ends",
             map.alloc_fails, map.free_hits);
    if (map.errors == 0 && map.outstanding() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
